>>> src/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

   // Pool geometry.
   localparam int unsigned POOL_DEPTH  = 64;
   localparam int unsigned SLOT_W      = 6;
   localparam int unsigned COUNT_W     = 7;

   // The free search splits the busy map into groups of eight slots.
   localparam int unsigned LOW_W       = 3;
   localparam int unsigned GROUP_SIZE  = 8;
   localparam int unsigned GROUP_CNT   = POOL_DEPTH / GROUP_SIZE;
   localparam int unsigned GROUP_W     = SLOT_W - LOW_W;

   // Field and register widths.
   localparam int unsigned BYTES_W     = 16;
   localparam int unsigned ALIGN_W     = 4;
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned SIZE_W      = 17;
   localparam int unsigned OFFSET_W    = SLOT_W + SIZE_W;
   localparam int unsigned MEM_W       = 23;
   localparam int unsigned MEM_PROD_W  = COUNT_W + SIZE_W;
   localparam int unsigned TOTAL_W     = 32;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [MEM_W-1:0] MEM_MAX = '1;

   // Request kinds.
   localparam logic [1:0] KIND_ACQUIRE = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_REJECTED  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_SLOTS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_BYTES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALIGN_LOG2   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 2'd3;

   // Configuration reset values.
   localparam logic [COUNT_W-1:0] POOL_SLOTS_RESET   = 7'd64;
   localparam logic [BYTES_W-1:0] BUFFER_BYTES_RESET = 16'd4096;
   localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RESET   = 4'd4;
   localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RESET = 32'd0;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] index;
   } free_search_type;

endpackage

`default_nettype wire

>>> src/fbpa_find_free.sv
`default_nettype none

// Lowest free usable slot: a per-group search followed by a search over groups.
module fbpa_find_free (
   input  wire logic [fbpa_pkg::POOL_DEPTH-1:0] busy_map,
   input  wire logic [fbpa_pkg::COUNT_W-1:0]    usable,
   output fbpa_pkg::free_search_type            search
);

   logic [fbpa_pkg::POOL_DEPTH-1:0] free_vec;
   logic [fbpa_pkg::GROUP_CNT-1:0]  group_hit;
   logic [fbpa_pkg::LOW_W-1:0]      group_low [fbpa_pkg::GROUP_CNT];

   always_comb begin
      for (int i = 0; i < fbpa_pkg::POOL_DEPTH; i++) begin
         free_vec[i] = !busy_map[i] && (fbpa_pkg::COUNT_W'(i) < usable);
      end
   end

   always_comb begin
      for (int g = 0; g < fbpa_pkg::GROUP_CNT; g++) begin
         group_hit[g] = |free_vec[g*fbpa_pkg::GROUP_SIZE +: fbpa_pkg::GROUP_SIZE];
         group_low[g] = '0;
         for (int b = fbpa_pkg::GROUP_SIZE - 1; b >= 0; b--) begin
            if (free_vec[g*fbpa_pkg::GROUP_SIZE + b]) begin
               group_low[g] = fbpa_pkg::LOW_W'(b);
            end
         end
      end
   end

   always_comb begin
      search.found = |group_hit;
      search.index = '0;
      for (int g = fbpa_pkg::GROUP_CNT - 1; g >= 0; g--) begin
         if (group_hit[g]) begin
            search.index = {fbpa_pkg::GROUP_W'(g), group_low[g]};
         end
      end
   end

endmodule

`default_nettype wire

>>> src/fbpa_addr_gen.sv
`default_nettype none

// Aligned buffer size, the address of one slot and the size of the whole pool.
module fbpa_addr_gen (
   input  wire logic [fbpa_pkg::SLOT_W-1:0]  slot_index,
   input  wire logic [fbpa_pkg::COUNT_W-1:0] usable,
   input  wire logic [fbpa_pkg::BYTES_W-1:0] buffer_bytes,
   input  wire logic [fbpa_pkg::ALIGN_W-1:0] align_log2,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]  base_address,
   output logic      [fbpa_pkg::ADDR_W-1:0]  buffer_address,
   output logic      [fbpa_pkg::MEM_W-1:0]   memory_total
);

   logic [fbpa_pkg::SIZE_W-1:0]     align_unit;
   logic [fbpa_pkg::SIZE_W-1:0]     rounded_size;
   logic [fbpa_pkg::OFFSET_W-1:0]   offset;
   logic [fbpa_pkg::MEM_PROD_W-1:0] mem_prod;

   always_comb begin
      align_unit   = fbpa_pkg::SIZE_W'(1) << align_log2;
      rounded_size = (fbpa_pkg::SIZE_W'(buffer_bytes) + align_unit - fbpa_pkg::SIZE_W'(1))
                     & ~(align_unit - fbpa_pkg::SIZE_W'(1));

      offset         = fbpa_pkg::OFFSET_W'(slot_index) * fbpa_pkg::OFFSET_W'(rounded_size);
      buffer_address = base_address + fbpa_pkg::ADDR_W'(offset);

      mem_prod = fbpa_pkg::MEM_PROD_W'(usable) * fbpa_pkg::MEM_PROD_W'(rounded_size);
      if (mem_prod > fbpa_pkg::MEM_PROD_W'(fbpa_pkg::MEM_MAX)) begin
         memory_total = fbpa_pkg::MEM_MAX;
      end else begin
         memory_total = mem_prod[fbpa_pkg::MEM_W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> src/fixed_block_pool_allocator.sv
`default_nettype none

// Fixed-block buffer pool with a 64-slot busy map. The block takes one transaction
// in every clock cycle: busy never rises, so start may be held high for as long as
// there are requests. A transaction is captured at the edge where start is high,
// and its result appears on the rsp_ ports, marked by rsp_strobe, once it has passed
// the request register and the result register, for exactly one cycle. The receiver
// cannot stall the result, so it must take every strobed result. Throughput is one
// transaction per cycle; each result takes a single pass from the request register
// through the lowest-free search and the address multiply into the result register,
// and the busy map and counters are updated at the same edge as the result register,
// so the next request already sees the new state. Every request yields one result
// that reports the status, the granted slot and address for a successful acquire
// (zero otherwise), and the pool occupancy and statistics after the request.
// The user must write the configuration registers through the csr_ port only while
// no transaction is in flight; the block itself does not enforce this.
module fixed_block_pool_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_kind,
   input  wire logic [fbpa_pkg::SLOT_W-1:0]       req_slot,

   output logic                                   rsp_strobe,
   output logic      [1:0]                        rsp_status,
   output logic      [fbpa_pkg::SLOT_W-1:0]       rsp_granted_slot,
   output logic      [fbpa_pkg::ADDR_W-1:0]       rsp_buffer_address,
   output logic      [fbpa_pkg::COUNT_W-1:0]      rsp_free_count,
   output logic      [fbpa_pkg::COUNT_W-1:0]      rsp_peak_count,
   output logic      [fbpa_pkg::TOTAL_W-1:0]      rsp_acquire_total,
   output logic      [fbpa_pkg::TOTAL_W-1:0]      rsp_failed_total,
   output logic      [fbpa_pkg::MEM_W-1:0]        rsp_memory_total,

   input  wire logic                              csr_we,
   input  wire logic [fbpa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic [fbpa_pkg::COUNT_W-1:0] pool_slots_ff;
   logic [fbpa_pkg::BYTES_W-1:0] buffer_bytes_ff;
   logic [fbpa_pkg::ALIGN_W-1:0] align_log2_ff;
   logic [fbpa_pkg::ADDR_W-1:0]  base_address_ff;

   // Request register.
   logic                         req_valid_ff;
   logic [1:0]                   kind_ff;
   logic [fbpa_pkg::SLOT_W-1:0]  slot_ff;

   // Pool state and statistics.
   logic [fbpa_pkg::POOL_DEPTH-1:0] busy_map_ff,    busy_map_in;
   logic [fbpa_pkg::COUNT_W-1:0]    busy_count_ff,  busy_count_in;
   logic [fbpa_pkg::COUNT_W-1:0]    peak_busy_ff,   peak_busy_in;
   logic [fbpa_pkg::TOTAL_W-1:0]    attempt_ff,     attempt_in;
   logic [fbpa_pkg::TOTAL_W-1:0]    failure_ff,     failure_in;

   // Result register.
   logic                            rsp_strobe_ff;
   logic [1:0]                      status_ff,      status_in;
   logic [fbpa_pkg::SLOT_W-1:0]     granted_ff,     granted_in;
   logic [fbpa_pkg::ADDR_W-1:0]     address_ff,     address_in;
   logic [fbpa_pkg::COUNT_W-1:0]    free_count_ff,  free_count_in;
   logic [fbpa_pkg::MEM_W-1:0]      memory_ff;

   logic [fbpa_pkg::COUNT_W-1:0]    usable;
   logic [fbpa_pkg::COUNT_W-1:0]    busy_count_inc;
   logic                            release_ok;
   logic [fbpa_pkg::ADDR_W-1:0]     slot_address;
   logic [fbpa_pkg::MEM_W-1:0]      memory_total;
   fbpa_pkg::free_search_type       search;

   // Every request is taken in the cycle it is offered.
   assign busy = 1'b0;

   // The slot field reaches only the first POOL_DEPTH slots, so a larger
   // configured count is capped here.
   assign usable = (pool_slots_ff > fbpa_pkg::COUNT_W'(fbpa_pkg::POOL_DEPTH))
                   ? fbpa_pkg::COUNT_W'(fbpa_pkg::POOL_DEPTH) : pool_slots_ff;

   fbpa_find_free u_find_free (
      .busy_map (busy_map_ff),
      .usable   (usable),
      .search   (search)
   );

   fbpa_addr_gen u_addr_gen (
      .slot_index     (search.index),
      .usable         (usable),
      .buffer_bytes   (buffer_bytes_ff),
      .align_log2     (align_log2_ff),
      .base_address   (base_address_ff),
      .buffer_address (slot_address),
      .memory_total   (memory_total)
   );

   assign busy_count_inc = busy_count_ff + fbpa_pkg::COUNT_W'(1);

   // A release must name a usable slot that is currently held. Slots above a
   // shrunken pool stay busy and cannot be released.
   assign release_ok = ({1'b0, slot_ff} < usable) && busy_map_ff[slot_ff];

   always_comb begin
      busy_map_in   = busy_map_ff;
      busy_count_in = busy_count_ff;
      peak_busy_in  = peak_busy_ff;
      attempt_in    = attempt_ff;
      failure_in    = failure_ff;
      status_in     = fbpa_pkg::STATUS_OK;
      granted_in    = '0;
      address_in    = '0;

      if (req_valid_ff) begin
         unique case (kind_ff)
            fbpa_pkg::KIND_ACQUIRE: begin
               attempt_in = (&attempt_ff) ? attempt_ff : attempt_ff + fbpa_pkg::TOTAL_W'(1);
               if (search.found) begin
                  busy_map_in[search.index] = 1'b1;
                  busy_count_in             = busy_count_inc;
                  if (busy_count_inc > peak_busy_ff) begin
                     peak_busy_in = busy_count_inc;
                  end
                  granted_in = search.index;
                  address_in = slot_address;
               end else begin
                  status_in  = fbpa_pkg::STATUS_EXHAUSTED;
                  failure_in = (&failure_ff) ? failure_ff
                                             : failure_ff + fbpa_pkg::TOTAL_W'(1);
               end
            end
            fbpa_pkg::KIND_RELEASE: begin
               if (release_ok) begin
                  busy_map_in[slot_ff] = 1'b0;
                  if (busy_count_ff != '0) begin
                     busy_count_in = busy_count_ff - fbpa_pkg::COUNT_W'(1);
                  end
               end else begin
                  status_in = fbpa_pkg::STATUS_REJECTED;
               end
            end
            fbpa_pkg::KIND_CLEAR: begin
               attempt_in   = '0;
               failure_in   = '0;
               peak_busy_in = busy_count_ff;
            end
            default: begin
               // The unused kind only reports the current figures.
            end
         endcase
      end

      // Free count is floored at zero, since busy slots may lie above a shrunken pool.
      free_count_in = (usable > busy_count_in) ? usable - busy_count_in : '0;
   end

   // Control state, configuration and pool state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_slots_ff   <= fbpa_pkg::POOL_SLOTS_RESET;
         buffer_bytes_ff <= fbpa_pkg::BUFFER_BYTES_RESET;
         align_log2_ff   <= fbpa_pkg::ALIGN_LOG2_RESET;
         base_address_ff <= fbpa_pkg::BASE_ADDRESS_RESET;
         req_valid_ff    <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         busy_map_ff     <= '0;
         busy_count_ff   <= '0;
         peak_busy_ff    <= '0;
         attempt_ff      <= '0;
         failure_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               fbpa_pkg::CSR_POOL_SLOTS:
                  pool_slots_ff   <= csr_wdata[fbpa_pkg::COUNT_W-1:0];
               fbpa_pkg::CSR_BUFFER_BYTES:
                  buffer_bytes_ff <= csr_wdata[fbpa_pkg::BYTES_W-1:0];
               fbpa_pkg::CSR_ALIGN_LOG2:
                  align_log2_ff   <= csr_wdata[fbpa_pkg::ALIGN_W-1:0];
               fbpa_pkg::CSR_BASE_ADDRESS:
                  base_address_ff <= csr_wdata[fbpa_pkg::ADDR_W-1:0];
               default: begin
               end
            endcase
         end
         req_valid_ff  <= start && !busy;
         rsp_strobe_ff <= req_valid_ff;
         busy_map_ff   <= busy_map_in;
         busy_count_ff <= busy_count_in;
         peak_busy_ff  <= peak_busy_in;
         attempt_ff    <= attempt_in;
         failure_ff    <= failure_in;
      end
   end

   // Request and result payload.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff <= req_kind;
         slot_ff <= req_slot;
      end
      if (req_valid_ff) begin
         status_ff     <= status_in;
         granted_ff    <= granted_in;
         address_ff    <= address_in;
         free_count_ff <= free_count_in;
         memory_ff     <= memory_total;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_slot   = granted_ff;
   assign rsp_buffer_address = address_ff;
   assign rsp_free_count     = free_count_ff;
   assign rsp_peak_count     = peak_busy_ff;
   assign rsp_acquire_total  = attempt_ff;
   assign rsp_failed_total   = failure_ff;
   assign rsp_memory_total   = memory_ff;

   // The busy count always matches the number of held slots in the map.
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_map_ff) == 32'(busy_count_ff))
      else $error("busy count differs from busy map population");

   // The peak never falls below the current busy count.
   a_peak_covers_count: assert property (@(posedge clock) disable iff (reset)
      peak_busy_ff >= busy_count_ff)
      else $error("peak below busy count");

   // Every captured transaction produces exactly one strobed result in the following cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_strobe)
      else $error("transaction produced no result");

   // An exhausted pool leaves no free usable slot.
   a_exhausted_no_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == fbpa_pkg::STATUS_EXHAUSTED) |-> rsp_free_count == '0)
      else $error("pool reported exhausted with free slots");

endmodule

`default_nettype wire
